### sv/rsenc_pkg.sv
package rsenc_pkg;

    localparam int MAX_DATA   = 16;
    localparam int MAX_PARITY = 4;

    localparam int COL_W    = 4;
    localparam int ROW_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int K_W      = 5;
    localparam int M_W      = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [K_W-1:0] K_RESET = 5'd4;
    localparam logic [M_W-1:0] M_RESET = 3'd2;
    localparam logic [K_W-1:0] K_LIMIT = 5'd16;
    localparam logic [M_W-1:0] M_LIMIT = 3'd4;

    localparam logic [8:0] GF_POLY = 9'h11d;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_SHARDS   = 8'd0,
        CFG_PARITY_SHARDS = 8'd1
    } cfg_reg_t;

    typedef logic [MAX_PARITY-1:0][BYTE_W-1:0] coef_col_t;

    // one data word on its way from the front to the lanes
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        coef_col_t         coef;
        logic              close;
        logic [M_W-1:0]    m_eff;
    } rsenc_job_t;

    // GF(2^8) product, shift and add, reduced by 0x11d
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                                 input logic [BYTE_W-1:0] y);
        logic [8:0]        a;
        logic [BYTE_W-1:0] r;
        a = {1'b0, x};
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (y[i]) begin
                r = r ^ a[BYTE_W-1:0];
            end
            a = {a[7:0], 1'b0};
            if (a[8]) begin
                a = a ^ GF_POLY;
            end
        end
        return r;
    endfunction

endpackage

### sv/rsenc_front.sv
module rsenc_front import rsenc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [ROW_W-1:0]  s_row_index,
    input  logic [COL_W-1:0]  s_column_index,
    input  logic [BYTE_W-1:0] s_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic       job_valid,
    input  logic       job_ready,
    output rsenc_job_t job
);

    logic [K_W-1:0] k_reg;
    logic [M_W-1:0] m_reg;
    logic [K_W-1:0] k_eff;
    logic [M_W-1:0] m_eff;

    coef_col_t coef_mem [MAX_DATA];
    coef_col_t coef_rd_reg;

    logic              fr_valid_reg;
    logic              fr_valid_next;
    logic [BYTE_W-1:0] fr_data_reg;
    logic              fr_close_reg;
    logic [M_W-1:0]    fr_m_reg;

    logic accept;
    logic in_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
            m_reg <= M_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_DATA_SHARDS) begin
                k_reg <= cfg_data[K_W-1:0];
            end else if (cfg_index == CFG_PARITY_SHARDS) begin
                m_reg <= cfg_data[M_W-1:0];
            end
        end
    end

    assign k_eff = (k_reg > K_LIMIT) ? K_LIMIT : k_reg;
    assign m_eff = (m_reg > M_LIMIT) ? M_LIMIT : m_reg;

    assign s_ready  = !fr_valid_reg || job_ready;
    assign accept   = s_valid && s_ready;
    assign in_range = ({1'b0, s_column_index} < k_eff);

    // one column holds every parity row's coefficient
    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_LOAD) begin
            coef_mem[s_column_index][s_row_index] <= s_value;
        end
        if (accept) begin
            coef_rd_reg <= coef_mem[s_column_index];
        end
    end

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (accept) begin
            fr_valid_next = (s_kind == KIND_DATA) && in_range;
        end else if (job_ready) begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_data_reg  <= s_value;
            fr_close_reg <= ({1'b0, s_column_index} == (k_eff - 5'd1));
            fr_m_reg     <= m_eff;
        end
    end

    assign job_valid  = fr_valid_reg;
    assign job.data   = fr_data_reg;
    assign job.coef   = coef_rd_reg;
    assign job.close  = fr_close_reg;
    assign job.m_eff  = fr_m_reg;

endmodule

### sv/rsenc_queue.sv
module rsenc_queue import rsenc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  rsenc_job_t in_job,
    output logic       out_valid,
    input  logic       out_ready,
    output rsenc_job_t out_job
);

    rsenc_job_t  entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

### sv/rsenc_back.sv
module rsenc_back import rsenc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  rsenc_job_t        job,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ROW_W-1:0]  m_parity_index,
    output logic [BYTE_W-1:0] m_parity_value,
    output logic              m_last
);

    logic [BYTE_W-1:0] acc_reg   [MAX_PARITY];
    logic [BYTE_W-1:0] acc_sum   [MAX_PARITY];
    logic [BYTE_W-1:0] drain_reg [MAX_PARITY];
    logic [ROW_W-1:0]  idx_reg;
    logic [M_W-1:0]    left_reg;
    logic              drain_free;
    logic              pop;
    logic              out_fire;

    assign out_fire   = m_valid && m_ready;
    assign drain_free = (left_reg == '0) || ((left_reg == 3'd1) && m_ready);
    assign job_ready  = !job.close || drain_free;
    assign pop        = job_valid && job_ready;

    always_comb begin
        for (int p = 0; p < MAX_PARITY; p++) begin
            acc_sum[p] = acc_reg[p] ^ gf_mul(job.coef[p], job.data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_PARITY; p++) begin
                acc_reg[p] <= '0;
            end
        end else if (pop) begin
            for (int p = 0; p < MAX_PARITY; p++) begin
                acc_reg[p] <= job.close ? '0 : acc_sum[p];
            end
        end
    end

    // snapshot finished lanes so accumulation of the next position runs on
    always_ff @(posedge aclk) begin
        if (pop && job.close) begin
            for (int p = 0; p < MAX_PARITY; p++) begin
                drain_reg[p] <= acc_sum[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            left_reg <= '0;
        end else if (pop && job.close) begin
            idx_reg  <= '0;
            left_reg <= job.m_eff;
        end else if (out_fire) begin
            idx_reg  <= idx_reg + 2'd1;
            left_reg <= left_reg - 3'd1;
        end
    end

    assign m_valid        = (left_reg != '0);
    assign m_parity_index = idx_reg;
    assign m_parity_value = drain_reg[idx_reg];
    assign m_last         = (left_reg == 3'd1);

endmodule

### sv/rs_erasure_parity_encoder.sv
// A closing data word goes through the front register, the queue and the drain buffer.
// Throughput: one input word per cycle while s_ready is high; a position's m parity words
//   leave one per cycle from a drain buffer while m_ready is high, so a closing word waits
//   only while parity words of the previous position are still draining.
// Reset: aresetn synchronous, active low; clears lanes, queue and drain, sets k=4, m=2.
//   The coefficient memory is not cleared and must be loaded before use.
module rs_erasure_parity_encoder import rsenc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [ROW_W-1:0]     s_row_index,
    input  logic [COL_W-1:0]     s_column_index,
    input  logic [BYTE_W-1:0]    s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ROW_W-1:0]     m_parity_index,
    output logic [BYTE_W-1:0]    m_parity_value,
    output logic                 m_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    rsenc_job_t front_job;
    rsenc_job_t back_job;
    logic       front_valid;
    logic       front_ready;
    logic       back_valid;
    logic       back_ready;

    rsenc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .s_value        (s_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .job_valid      (front_valid),
        .job_ready      (front_ready),
        .job            (front_job)
    );

    rsenc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    rsenc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (back_valid),
        .job_ready      (back_ready),
        .job            (back_job),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parity_index (m_parity_index),
        .m_parity_value (m_parity_value),
        .m_last         (m_last)
    );

endmodule
